/* design/serial_frame_deframer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Serial frame deframer assertion macros
// Concurrent check helpers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define SFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sfd check failed");
// Next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sfd check failed");
`else
`define SFD_ASSERT_IMPL(label, ante, cons)
`define SFD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* design/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Shared constants, status codes, parser phases and the structs passed
// between the top level and the parser.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Frame delimiters and the fixed overhead added to the payload length in the max-frame check
    localparam logic [7:0]  HDR_BYTE       = 8'hA5;
    localparam logic [7:0]  TRL_BYTE       = 8'h5A;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd6;

    // Configuration register reset values
    localparam logic [15:0] TIMEOUT_RST    = 16'd1000;
    localparam logic        CSUM_EN_RST    = 1'b1;
    localparam logic [16:0] MAX_FRAME_RST  = 17'd128;

    // Configuration register indexes (word address)
    localparam logic [1:0]  REG_TIMEOUT    = 2'd0;
    localparam logic [1:0]  REG_CSUM_EN    = 2'd1;
    localparam logic [1:0]  REG_MAX_FRAME  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_HEADER   = 3'd1,
        ST_BAD_CHECKSUM = 3'd2,
        ST_BAD_TRAILER  = 3'd3,
        ST_BAD_LENGTH   = 3'd4,
        ST_TIMEOUT      = 3'd5
    } t_status;

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_HDR2    = 8'b0000_0010,
        PH_LEN_HI  = 8'b0000_0100,
        PH_LEN_LO  = 8'b0000_1000,
        PH_PAYLOAD = 8'b0001_0000,
        PH_CSUM    = 8'b0010_0000,
        PH_TRL1    = 8'b0100_0000,
        PH_TRL2    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic        checksum_enable;
        logic [16:0] max_frame_bytes;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [7:0]  payload_byte;
        logic        frame_end;
        t_status     status;
        logic [15:0] payload_count;
    } t_result;

endpackage

/* design/sfd_parser.sv */
// ----------------------------------------------------------------------------
// Serial frame deframer parser
// Frame state and the single-pass update for one byte or timer tick,
// producing at most one payload or status result.
// ----------------------------------------------------------------------------
module sfd_parser
    import sfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_action,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase      r_phase,   n_phase;
    logic [15:0] r_len,     n_len;
    logic [16:0] r_seen,    n_seen;
    logic [7:0]  r_sum,     n_sum;
    logic [15:0] r_idle,    n_idle;

    logic        do_close;
    t_status     close_status;
    logic [15:0] close_count;
    logic [15:0] len_full;

    assign len_full = r_len | {8'h00, i_byte};

    // Work out the next frame state and the result of this beat
    always_comb begin
        n_phase      = r_phase;
        n_len        = r_len;
        n_seen       = r_seen;
        n_sum        = r_sum;
        n_idle       = r_idle;
        do_close     = 1'b0;
        close_status = ST_OK;
        close_count  = 16'd0;
        o_result     = '0;

        if (i_step) begin
            if (i_action) begin
                // Count mid-frame silence, saturating
                if (r_phase != PH_HUNT) begin
                    if (r_idle != 16'hFFFF) begin
                        n_idle = r_idle + 16'd1;
                    end
                    if (n_idle >= i_cfg.timeout_ticks) begin
                        do_close     = 1'b1;
                        close_status = ST_TIMEOUT;
                        close_count  = r_seen[15:0];
                    end
                end
            end else begin
                n_idle = 16'd0;
                case (r_phase)
                    PH_HUNT: begin
                        if (i_byte == HDR_BYTE) begin
                            n_phase = PH_HDR2;
                        end
                    end
                    PH_HDR2: begin
                        if (i_byte != HDR_BYTE) begin
                            do_close     = 1'b1;
                            close_status = ST_BAD_HEADER;
                        end else begin
                            n_phase = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        n_len   = {i_byte, 8'h00};
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_len = len_full;
                        if (len_full == 16'd0 ||
                            ({1'b0, len_full} + FRAME_OVERHEAD) > i_cfg.max_frame_bytes) begin
                            do_close     = 1'b1;
                            close_status = ST_BAD_LENGTH;
                        end else begin
                            n_seen  = 17'd0;
                            n_sum   = 8'd0;
                            n_phase = (len_full == 16'd1) ? PH_CSUM : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_sum  = r_sum + i_byte;
                        n_seen = r_seen + 17'd1;
                        if ((n_seen + 17'd1) >= {1'b0, r_len}) begin
                            n_phase = PH_CSUM;
                        end
                        o_result.valid         = 1'b1;
                        o_result.payload_byte  = i_byte;
                        o_result.payload_count = n_seen[15:0];
                    end
                    PH_CSUM: begin
                        n_sum   = (i_cfg.checksum_enable && r_sum != i_byte) ? 8'd1 : 8'd0;
                        n_phase = PH_TRL1;
                    end
                    PH_TRL1: begin
                        if (i_byte != TRL_BYTE) begin
                            do_close     = 1'b1;
                            close_status = ST_BAD_TRAILER;
                            close_count  = r_seen[15:0];
                        end else begin
                            n_phase = PH_TRL2;
                        end
                    end
                    PH_TRL2: begin
                        do_close    = 1'b1;
                        close_count = r_seen[15:0];
                        if (i_byte != TRL_BYTE) begin
                            close_status = ST_BAD_TRAILER;
                        end else if (r_sum != 8'd0) begin
                            close_status = ST_BAD_CHECKSUM;
                        end else begin
                            close_status = ST_OK;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end

            // Close the frame: emit status and go back to hunting
            if (do_close) begin
                o_result.valid         = 1'b1;
                o_result.frame_end     = 1'b1;
                o_result.status        = close_status;
                o_result.payload_count = close_count;
                n_phase = PH_HUNT;
                n_len   = 16'd0;
                n_seen  = 17'd0;
                n_sum   = 8'd0;
                n_idle  = 16'd0;
            end
        end
    end

    // Hold frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= 16'd0;
            r_seen  <= 17'd0;
            r_sum   <= 8'd0;
            r_idle  <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
            r_idle  <= n_idle;
        end
    end

endmodule

/* design/serial_frame_deframer_unit.sv */
// Any result of an accepted input beat passes through the input register,
// then the result register. Throughput: one beat per cycle unless the output stalls;
// the parser state updates once per beat.
// Reset: synchronous, active low; clears the parser to hunting, empties both
// registers and loads the configuration defaults (timeout 1000, checksum on, max 128).
// ----------------------------------------------------------------------------
// Serial frame deframer unit
// Parses A5 A5 / length / payload / checksum / 5A 5A frames from a byte and
// tick stream, passing payload bytes out and closing each frame with a status.
// ----------------------------------------------------------------------------
`include "serial_frame_deframer_unit_defines.svh"

module serial_frame_deframer_unit
    import sfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] action (0 byte, 1 tick)
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] payload_count
    output logic        m_axis_tlast,   // frame_end
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_in_action;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    t_status     r_out_status;
    logic [15:0] r_out_count;

    logic        advance;
    logic        cfg_wr;
    t_result     result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks   <= TIMEOUT_RST;
            r_cfg.checksum_enable <= CSUM_EN_RST;
            r_cfg.max_frame_bytes <= MAX_FRAME_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TIMEOUT:   r_cfg.timeout_ticks   <= pwdata[15:0];
                REG_CSUM_EN:   r_cfg.checksum_enable <= pwdata[0];
                REG_MAX_FRAME: r_cfg.max_frame_bytes <= pwdata[16:0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (paddr[3:2])
            REG_TIMEOUT:   prdata = {16'd0, r_cfg.timeout_ticks};
            REG_CSUM_EN:   prdata = {31'd0, r_cfg.checksum_enable};
            REG_MAX_FRAME: prdata = {15'd0, r_cfg.max_frame_bytes};
            default:       prdata = 32'd0;
        endcase
    end

    // Advance a beat into the parser when the result register is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= s_axis_tuser;
            r_in_byte   <= s_axis_tdata;
        end
    end

    sfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_action (r_in_action),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out_byte   <= result.payload_byte;
            r_out_last   <= result.frame_end;
            r_out_status <= result.status;
            r_out_count  <= result.payload_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_out_byte};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_status;

    // Checks
    `SFD_ASSERT_IMPL(a_stall_blocks_input, r_in_valid && r_out_valid && !m_axis_tready, !s_axis_tready)
    `SFD_ASSERT_IMPL(a_status_beat_no_byte, m_axis_tvalid && m_axis_tlast, m_axis_tdata[7:0] == 8'd0)
    `SFD_ASSERT_IMPL(a_payload_beat_ok, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == ST_OK)
    `SFD_ASSERT_NEXT(a_result_kept, r_out_valid && !m_axis_tready, r_out_valid)

endmodule
